// ----- hdl/mats_pkg.sv -----
`default_nettype none
package mats_pkg;

  localparam int MAX_ARMS    = 4;
  localparam int MAX_ACTIONS = 64;
  localparam int JOINTS      = 7;
  localparam int POS_BITS    = 20;

  localparam int ARM_W    = 2;
  localparam int SLOT_W   = 6;
  localparam int JOINT_W  = 3;
  localparam int STEP_W   = 20;
  localparam int STEPSZ_W = 19;
  localparam int HOLD_W   = 16;
  localparam int CNT_W    = 7;
  localparam int CSTEP_W  = 21;
  localparam int NARM_W   = 3;
  localparam int JADDR_W  = ARM_W + SLOT_W + JOINT_W;
  localparam int HADDR_W  = ARM_W + SLOT_W;
  localparam int PROD_W   = 2 * POS_BITS;

  localparam logic [1:0] FUNC_LOAD_JOINT = 2'd0;
  localparam logic [1:0] FUNC_LOAD_HDR   = 2'd1;
  localparam logic [1:0] FUNC_TICK       = 2'd2;

  localparam logic [2:0] ST_LOADED  = 3'd0;
  localparam logic [2:0] ST_PUBLISH = 3'd1;
  localparam logic [2:0] ST_WAIT    = 3'd2;
  localparam logic [2:0] ST_HOLD    = 3'd3;
  localparam logic [2:0] ST_ADVANCE = 3'd4;
  localparam logic [2:0] ST_IDLE    = 3'd5;

  typedef logic signed [POS_BITS-1:0] pos_t;
  typedef pos_t [JOINTS-1:0] pos_arr_t;

  typedef struct packed {
    logic               capture;
    logic               j_we;
    logic [JADDR_W-1:0] jaddr;
    logic               h_we;
    logic [HADDR_W-1:0] haddr;
    logic               act_latch;
    logic               best_clr;
    logic               diff;
    logic               mul;
    logic               div_start;
    logic               acc;
    logic               mode_tick;
    logic [JOINT_W-1:0] jsel;
    logic [STEP_W-1:0]  s_val;
  } dp_cmd_t;

  typedef struct packed {
    logic              tog_q;
    logic [STEP_W-1:0] step_q;
    logic [HOLD_W-1:0] hold_q;
    logic              div_busy;
  } dp_stat_t;

  typedef struct packed {
    logic             valid;
    logic [2:0]       status;
    logic [ARM_W-1:0] arm;
  } res_t;

endpackage
`default_nettype wire

// ----- hdl/multi_arm_trajectory_sequencer.sv -----
// multi-arm linear joint trajectory sequencer
// input channel (in_valid/in_ready) carries one command item: func selects a
//   joint endpoint load, an action header load, or a tick for one arm
// output channel (out_valid/out_ready) returns exactly one result item per
//   command: status, the arm, and seven joint positions (zero unless published)
// cfg_we/cfg_data write active arm count; user writes only while idle, unchecked
// a header load or a publishing tick runs the shared restoring divider once
//   per joint; a zero-step tick skips the divider; a barrier tick scans all
//   active arms
// throughput: one item at a time, the next item is taken once the result has
//   moved into the output register
// reset clears all per-arm progress, sync state and the arm count (to 3); the
//   action tables are not cleared and must be loaded before use
// when the receiver stalls, the result sits in the output register and the
//   controller holds the next result until that register frees up
`default_nettype none
module multi_arm_trajectory_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [1:0]  arm,
  input  logic [5:0]  slot,
  input  logic [2:0]  joint,
  input  logic signed [19:0] start_pos,
  input  logic signed [19:0] end_pos,
  input  logic [18:0] step_size,
  input  logic [15:0] hold_ticks,
  input  logic        together,
  input  logic [6:0]  action_count,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [1:0]  arm_out,
  output logic signed [19:0] pos0,
  output logic signed [19:0] pos1,
  output logic signed [19:0] pos2,
  output logic signed [19:0] pos3,
  output logic signed [19:0] pos4,
  output logic signed [19:0] pos5,
  output logic signed [19:0] pos6
);
  import mats_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  res_t     res;
  pos_arr_t pos;
  logic     out_free;
  logic     pub;

  // output register frees when empty or being taken this cycle
  assign out_free = !out_valid || out_ready;
  assign pub      = (res.status == ST_PUBLISH);

  mats_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .arm          (arm),
    .slot         (slot),
    .joint        (joint),
    .action_count (action_count),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .out_free     (out_free),
    .stat         (stat),
    .cmd          (cmd),
    .res          (res)
  );

  mats_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .start_pos  (start_pos),
    .end_pos    (end_pos),
    .step_size  (step_size),
    .hold_ticks (hold_ticks),
    .together   (together),
    .stat       (stat),
    .pos        (pos)
  );

  // result output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // positions are only meaningful on a publish, zero otherwise
  always_ff @(posedge clk) begin
    if (res.valid) begin
      status  <= res.status;
      arm_out <= res.arm;
      pos0    <= pub ? pos[0] : '0;
      pos1    <= pub ? pos[1] : '0;
      pos2    <= pub ? pos[2] : '0;
      pos3    <= pub ? pos[3] : '0;
      pos4    <= pub ? pos[4] : '0;
      pos5    <= pub ? pos[5] : '0;
      pos6    <= pub ? pos[6] : '0;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/mats_dp.sv -----
`default_nettype none
module mats_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  mats_pkg::dp_cmd_t               cmd,
  input  logic signed [mats_pkg::POS_BITS-1:0] start_pos,
  input  logic signed [mats_pkg::POS_BITS-1:0] end_pos,
  input  logic [mats_pkg::STEPSZ_W-1:0]   step_size,
  input  logic [mats_pkg::HOLD_W-1:0]     hold_ticks,
  input  logic                            together,
  output mats_pkg::dp_stat_t              stat,
  output mats_pkg::pos_arr_t              pos
);
  import mats_pkg::*;

  localparam int JDEPTH = 2 ** JADDR_W;
  localparam int HDEPTH = 2 ** HADDR_W;

  // captured item payload
  logic signed [POS_BITS-1:0] st_c, en_c;
  logic [STEPSZ_W-1:0] stepsz_c;
  logic [HOLD_W-1:0]   hold_c;
  logic                tog_c;

  logic signed [POS_BITS-1:0] smem [JDEPTH];
  logic signed [POS_BITS-1:0] emem [JDEPTH];
  logic [STEP_W-1:0] step_mem [HDEPTH];
  logic [HOLD_W-1:0] hold_mem [HDEPTH];
  logic              tog_mem  [HDEPTH];

  logic signed [POS_BITS-1:0] start_q, end_q;
  logic [STEP_W-1:0] step_q, act_steps;
  logic [HOLD_W-1:0] hold_q;
  logic              tog_q;

  logic signed [POS_BITS:0] d;
  logic [POS_BITS:0]        mag;
  logic signed [POS_BITS-1:0] st_r;
  logic                     neg;
  logic [POS_BITS-1:0]      mag_r;
  logic [PROD_W-1:0]        prod;

  logic [STEP_W-1:0] den;
  logic [STEP_W-1:0] rem, quo, best;
  logic [4:0]        dcnt;
  logic [STEP_W:0]   t, tsub;
  logic              ge;
  logic [POS_BITS:0] sum, qext;
  pos_arr_t          pos_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      st_c     <= start_pos;
      en_c     <= end_pos;
      stepsz_c <= step_size;
      hold_c   <= hold_ticks;
      tog_c    <= together;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.j_we) begin
      smem[cmd.jaddr] <= st_c;
      emem[cmd.jaddr] <= en_c;
    end
    start_q <= smem[cmd.jaddr];
    end_q   <= emem[cmd.jaddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.h_we) begin
      step_mem[cmd.haddr] <= best;
      hold_mem[cmd.haddr] <= hold_c;
      tog_mem[cmd.haddr]  <= tog_c;
    end
    step_q <= step_mem[cmd.haddr];
    hold_q <= hold_mem[cmd.haddr];
    tog_q  <= tog_mem[cmd.haddr];
  end

  // difference and magnitude
  always_comb begin
    d   = {end_q[POS_BITS-1], end_q} - {start_q[POS_BITS-1], start_q};
    mag = d[POS_BITS] ? (~d + 1'b1) : d;
  end

  always_comb begin
    if (cmd.mode_tick) begin
      den = act_steps;
    end else if (stepsz_c == '0) begin
      den = STEP_W'(1);
    end else begin
      den = {1'b0, stepsz_c};
    end
    t    = {rem, quo[STEP_W-1]};
    tsub = t - {1'b0, den};
    ge   = (t >= {1'b0, den});
    qext = neg ? (~{1'b0, quo} + 1'b1) : {1'b0, quo};
    sum  = {st_r[POS_BITS-1], st_r} + qext;
  end

  always_ff @(posedge clk) begin
    if (cmd.act_latch) begin
      act_steps <= step_q;
    end
    if (cmd.diff) begin
      st_r  <= start_q;
      neg   <= d[POS_BITS];
      mag_r <= mag[POS_BITS-1:0];
    end
    if (cmd.mul) begin
      prod <= cmd.mode_tick ? (PROD_W'(mag_r) * PROD_W'(cmd.s_val))
                            : PROD_W'(mag_r);
    end
    if (cmd.best_clr) begin
      best <= '0;
    end else if (cmd.acc && !cmd.mode_tick && quo > best) begin
      best <= quo;
    end
    if (cmd.acc && cmd.mode_tick) begin
      pos_r[cmd.jsel] <= (act_steps == '0) ? st_r : sum[POS_BITS-1:0];
    end
  end

  // restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      dcnt <= '0;
    end else if (cmd.div_start) begin
      rem  <= prod[PROD_W-1:STEP_W];
      quo  <= prod[STEP_W-1:0];
      dcnt <= 5'(STEP_W);
    end else if (dcnt != '0) begin
      rem  <= ge ? tsub[STEP_W-1:0] : t[STEP_W-1:0];
      quo  <= {quo[STEP_W-2:0], ge};
      dcnt <= dcnt - 1'b1;
    end
  end

  assign stat.tog_q    = tog_q;
  assign stat.step_q   = step_q;
  assign stat.hold_q   = hold_q;
  assign stat.div_busy = (dcnt != '0);
  assign pos           = pos_r;

endmodule
`default_nettype wire

// ----- hdl/mats_ctrl.sv -----
`default_nettype none
module mats_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    func,
  input  logic [mats_pkg::ARM_W-1:0]    arm,
  input  logic [mats_pkg::SLOT_W-1:0]   slot,
  input  logic [mats_pkg::JOINT_W-1:0]  joint,
  input  logic [mats_pkg::CNT_W-1:0]    action_count,
  input  logic                          cfg_we,
  input  logic [mats_pkg::NARM_W-1:0]   cfg_data,
  input  logic                          out_free,
  input  mats_pkg::dp_stat_t            stat,
  output mats_pkg::dp_cmd_t             cmd,
  output mats_pkg::res_t                res
);
  import mats_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_TSTART = 4'd2;
  localparam logic [3:0] S_TDEC   = 4'd3;
  localparam logic [3:0] S_JRD    = 4'd4;
  localparam logic [3:0] S_JDIFF  = 4'd5;
  localparam logic [3:0] S_JMUL   = 4'd6;
  localparam logic [3:0] S_JDIV   = 4'd7;
  localparam logic [3:0] S_JDWAIT = 4'd8;
  localparam logic [3:0] S_JACC   = 4'd9;
  localparam logic [3:0] S_HWR    = 4'd10;
  localparam logic [3:0] S_SCA    = 4'd11;
  localparam logic [3:0] S_SCD    = 4'd12;
  localparam logic [3:0] S_RES    = 4'd13;

  logic [3:0] state;
  logic [1:0] f_c;
  logic [ARM_W-1:0]   arm_c;
  logic [SLOT_W-1:0]  slot_c;
  logic [JOINT_W-1:0] joint_c, jidx;
  logic [CNT_W-1:0]   cnt_c;
  logic [ARM_W:0]     b;
  logic               flag, scan_clr, steps_zero;
  logic [2:0]         res_st;
  logic [NARM_W-1:0]  arm_cfg, n;

  logic [CNT_W-1:0]   loaded   [MAX_ARMS];
  logic [CNT_W-1:0]   cur      [MAX_ARMS];
  logic [CSTEP_W-1:0] cur_step [MAX_ARMS];
  logic               hact     [MAX_ARMS];
  logic [HOLD_W-1:0]  hel      [MAX_ARMS];
  logic               waitf    [MAX_ARMS];
  logic               sync;

  logic [HOLD_W-1:0]  hel_inc;
  logic [ARM_W-1:0]   bi;

  function automatic logic fin(input logic [ARM_W-1:0] x);
    return cur[x] >= loaded[x];
  endfunction

  always_comb begin
    n       = (arm_cfg > NARM_W'(MAX_ARMS)) ? NARM_W'(MAX_ARMS) : arm_cfg;
    bi      = b[ARM_W-1:0];
    hel_inc = (hel[arm_c] != '1) ? hel[arm_c] + 1'b1 : hel[arm_c];
  end

  always_comb begin
    cmd           = '0;
    cmd.capture   = in_valid && in_ready;
    cmd.mode_tick = (f_c == FUNC_TICK);
    cmd.jsel      = jidx;
    cmd.s_val     = cur_step[arm_c][STEP_W-1:0];
    if (state == S_JRD) begin
      cmd.jaddr = {arm_c, (f_c == FUNC_TICK) ? cur[arm_c][SLOT_W-1:0] : slot_c, jidx};
    end else begin
      cmd.jaddr = {arm_c, slot_c, joint_c};
    end
    cmd.j_we = (state == S_DISP) && (f_c == FUNC_LOAD_JOINT) &&
               (joint_c < JOINT_W'(JOINTS));
    if (state == S_SCA) begin
      cmd.haddr = {bi, cur[bi][SLOT_W-1:0]};
    end else if (state == S_TSTART) begin
      cmd.haddr = {arm_c, cur[arm_c][SLOT_W-1:0]};
    end else begin
      cmd.haddr = {arm_c, slot_c};
    end
    cmd.h_we      = (state == S_HWR);
    cmd.act_latch = (state == S_TDEC);
    cmd.best_clr  = (state == S_DISP);
    cmd.diff      = (state == S_JDIFF);
    cmd.mul       = (state == S_JMUL);
    cmd.div_start = (state == S_JDIV);
    cmd.acc       = (state == S_JACC);
  end

  assign in_ready   = (state == S_IDLE);
  assign res.valid  = (state == S_RES) && out_free;
  assign res.status = res_st;
  assign res.arm    = arm_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      arm_cfg <= NARM_W'(3);
    end else if (cfg_we) begin
      arm_cfg <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sync  <= 1'b0;
      for (int i = 0; i < MAX_ARMS; i++) begin
        loaded[i]   <= '0;
        cur[i]      <= '0;
        cur_step[i] <= '0;
        hact[i]     <= 1'b0;
        hel[i]      <= '0;
        waitf[i]    <= 1'b0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            f_c     <= func;
            arm_c   <= arm;
            slot_c  <= slot;
            joint_c <= joint;
            cnt_c   <= action_count;
            state   <= S_DISP;
          end
        end
        S_DISP: begin
          jidx <= '0;
          case (f_c)
            FUNC_LOAD_JOINT: begin
              res_st <= ST_LOADED;
              state  <= S_RES;
            end
            FUNC_LOAD_HDR: state <= S_JRD;
            FUNC_TICK:     state <= S_TSTART;
            default: begin
              res_st <= ST_IDLE;
              state  <= S_RES;
            end
          endcase
        end
        S_TSTART: begin
          if ({1'b0, arm_c} >= n || fin(arm_c)) begin
            res_st <= ST_IDLE;
            state  <= S_RES;
          end else begin
            state <= S_TDEC;
          end
        end
        S_TDEC: begin
          steps_zero <= (stat.step_q == '0);
          if (stat.tog_q && !sync && !waitf[arm_c]) begin
            waitf[arm_c] <= 1'b1;
            b        <= '0;
            flag     <= 1'b1;
            scan_clr <= 1'b0;
            state    <= S_SCA;
          end else if (stat.tog_q && !sync) begin
            res_st <= ST_WAIT;
            state  <= S_RES;
          end else if (cur_step[arm_c] <= CSTEP_W'(stat.step_q)) begin
            jidx  <= '0;
            state <= S_JRD;
          end else begin
            if (!stat.tog_q && stat.hold_q != '0) begin
              if (!hact[arm_c]) begin
                hact[arm_c] <= 1'b1;
                hel[arm_c]  <= '0;
                res_st      <= ST_HOLD;
              end else begin
                hel[arm_c] <= hel_inc;
                if (hel_inc >= stat.hold_q) begin
                  hact[arm_c]     <= 1'b0;
                  cur[arm_c]      <= cur[arm_c] + 1'b1;
                  cur_step[arm_c] <= '0;
                  res_st          <= ST_ADVANCE;
                end else begin
                  res_st <= ST_HOLD;
                end
              end
            end else begin
              cur[arm_c]      <= cur[arm_c] + 1'b1;
              cur_step[arm_c] <= '0;
              res_st          <= ST_ADVANCE;
            end
            if (stat.tog_q) begin
              b        <= '0;
              flag     <= 1'b1;
              scan_clr <= 1'b1;
              state    <= S_SCA;
            end else begin
              state <= S_RES;
            end
          end
        end
        S_JRD:   state <= S_JDIFF;
        S_JDIFF: begin
          if (f_c == FUNC_TICK && steps_zero) begin
            state <= S_JACC;
          end else begin
            state <= S_JMUL;
          end
        end
        S_JMUL:  state <= S_JDIV;
        S_JDIV:  state <= S_JDWAIT;
        S_JDWAIT: begin
          if (!stat.div_busy) begin
            state <= S_JACC;
          end
        end
        S_JACC: begin
          if (jidx == JOINT_W'(JOINTS - 1)) begin
            if (f_c == FUNC_TICK) begin
              cur_step[arm_c] <= cur_step[arm_c] + 1'b1;
              res_st          <= ST_PUBLISH;
              state           <= S_RES;
            end else begin
              state <= S_HWR;
            end
          end else begin
            jidx  <= jidx + 1'b1;
            state <= S_JRD;
          end
        end
        S_HWR: begin
          loaded[arm_c] <= (cnt_c > CNT_W'(MAX_ACTIONS)) ? CNT_W'(MAX_ACTIONS) : cnt_c;
          res_st        <= ST_LOADED;
          state         <= S_RES;
        end
        S_SCA: begin
          if (b >= n) begin
            if (scan_clr) begin
              if (flag) begin
                sync <= 1'b0;
              end
            end else begin
              if (flag) begin
                sync <= 1'b1;
                for (int i = 0; i < MAX_ARMS; i++) begin
                  if (NARM_W'(i) < n) begin
                    waitf[i] <= 1'b0;
                  end
                end
              end
              res_st <= ST_WAIT;
            end
            state <= S_RES;
          end else if (fin(bi)) begin
            b <= b + 1'b1;
          end else begin
            state <= S_SCD;
          end
        end
        S_SCD: begin
          // clear scan: any arm still on a together action keeps sync
          // wait scan: every unfinished arm must be on a together action and waiting
          if (scan_clr ? stat.tog_q : (!stat.tog_q || !waitf[bi])) begin
            flag <= 1'b0;
          end
          b     <= b + 1'b1;
          state <= S_SCA;
        end
        S_RES: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
